FILE: rtl/sfp_pkg.sv
// sfp_pkg: shared types, constants and arithmetic helpers of the strain field post-filter
// no dependencies; imported by every module of the block

package sfp_pkg;

  // fixed field widths
  localparam int SAMPLE_W    = 24;
  localparam int GAIN_W      = 16;
  localparam int STRAIN_W    = 32;
  localparam int NUM_BEAMS_W = 8;
  localparam int NUM_SAMP_W  = 12;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 16;
  localparam int BEAM_OUT_W  = 7;
  localparam int SAMP_OUT_W  = 11;
  localparam int LP_PROD_W   = SAMPLE_W + 1 + GAIN_W + 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_BEAMS   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWPASS     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIFF_GAIN   = 4'd3;

  // register reset values and geometry floors
  localparam logic [NUM_BEAMS_W-1:0] RST_NUM_BEAMS = 8'd128;
  localparam logic [NUM_SAMP_W-1:0]  RST_SAMPLES   = 12'd2048;
  localparam logic [GAIN_W-1:0]      RST_LOWPASS   = 16'd5644;
  localparam logic [GAIN_W-1:0]      RST_DIFF_GAIN = 16'd2185;
  localparam int MIN_BEAMS   = 2;
  localparam int MIN_SAMPLES = 16;

  // sequencer states
  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_AX,
    S_AXY,
    S_LAT,
    S_LATZ,
    S_DIFF,
    S_ACC
  } sfp_state_t;

  // strain store access control
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } st_ctl_t;

  // median of three
  function automatic logic signed [SAMPLE_W-1:0] med3(
    input logic signed [SAMPLE_W-1:0] a,
    input logic signed [SAMPLE_W-1:0] b,
    input logic signed [SAMPLE_W-1:0] c
  );
    logic signed [SAMPLE_W-1:0] lo;
    logic signed [SAMPLE_W-1:0] hi;
    logic signed [SAMPLE_W-1:0] m;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    m  = (hi < c) ? hi : c;
    return (lo > m) ? lo : m;
  endfunction

  // base plus rounded Q0.16 product, result stays within 24 bits
  function automatic logic signed [SAMPLE_W-1:0] lp_apply(
    input logic signed [SAMPLE_W-1:0]  base,
    input logic signed [LP_PROD_W-1:0] prod
  );
    logic signed [LP_PROD_W-1:0] t;
    logic signed [SAMPLE_W+1:0]  r;
    logic signed [SAMPLE_W+1:0]  s;
    t = prod + LP_PROD_W'(32768);
    r = (SAMPLE_W+2)'(t >>> 16);
    s = (SAMPLE_W+2)'(base) + r;
    return s[SAMPLE_W-1:0];
  endfunction

endpackage

FILE: rtl/sfp_strain_store.sv
// sfp_strain_store: frame-persistent strain memory with a clearing sweep after reset
// depends on sfp_pkg

module sfp_strain_store
  import sfp_pkg::*;
#(
  parameter int DEPTH = 262144,
  parameter int AW    = 18
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  st_ctl_t                     ctl,
  input  logic [AW-1:0]               addr,
  input  logic signed [STRAIN_W-1:0]  wdata,
  output logic signed [STRAIN_W-1:0]  rdata,
  output logic                        busy
);

  logic signed [STRAIN_W-1:0] mem [DEPTH];
  logic [AW-1:0] clr_cnt_r;
  logic          busy_r;
  logic signed [STRAIN_W-1:0] rdata_r;

  // clearing sweep, one entry a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      clr_cnt_r <= '0;
    end else if (busy_r) begin
      if (clr_cnt_r == AW'(DEPTH - 1)) begin
        busy_r <= 1'b0;
      end
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[clr_cnt_r] <= '0;
    end else if (ctl.wr_en) begin
      mem[addr] <= wdata;
    end
    if (ctl.rd_en) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;
  assign busy  = busy_r;

endmodule

FILE: rtl/strain_field_postfilter.sv
// strain_field_postfilter: median, axial and lateral low pass, differentiator, strain store
// depends on sfp_pkg and sfp_strain_store
//
//  channel | ports                                       | direction
//  --------+---------------------------------------------+----------
//  in      | in_valid in_ready in_shift_sample           | in
//  out     | out_valid out_ready out_beam_index          | out
//          | out_sample_index out_strain_sum out_frame_last |
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data      | in
//
// a word is accepted in S_IDLE, then each filtered point runs S_AX, S_AXY, S_LAT and S_LATZ
// (no point when it starts a beam), plus S_DIFF and S_ACC per point that updates the strain store
// (up to two points per word); a new word is taken only when the last one is done.
// after reset a clearing sweep over all MAX_BEAMS*MAX_SAMPLES store entries runs before in_ready rises.
// an output stall holds the sequencer at the store write until the output register frees.
// register writes are taken only while idle or clearing the store and win over an input word in the same cycle.

module strain_field_postfilter
  import sfp_pkg::*;
#(
  parameter int MAX_BEAMS   = 128,
  parameter int MAX_SAMPLES = 2048,
  parameter int HALF_LEN    = 5
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [SAMPLE_W-1:0]  in_shift_sample,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [BEAM_OUT_W-1:0]       out_beam_index,
  output logic [SAMP_OUT_W-1:0]       out_sample_index,
  output logic signed [STRAIN_W-1:0]  out_strain_sum,
  output logic                        out_frame_last,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data
);

  localparam int BW    = $clog2(MAX_BEAMS);
  localparam int SW    = $clog2(MAX_SAMPLES);
  localparam int NBW   = $clog2(MAX_BEAMS + 1);
  localparam int NSW   = $clog2(MAX_SAMPLES + 1);
  localparam int ZB    = (NBW > NUM_BEAMS_W) ? NBW : NUM_BEAMS_W;
  localparam int ZS    = (NSW > NUM_SAMP_W) ? NSW : NUM_SAMP_W;
  localparam int DLEN  = 2 * HALF_LEN + 1;
  localparam int SUMW  = SAMPLE_W + $clog2(HALF_LEN) + 2;
  localparam int DPW   = SUMW + GAIN_W + 1;
  localparam int DW    = DPW - 12;
  localparam int ACW   = ((DW > STRAIN_W) ? DW : STRAIN_W) + 1;
  localparam int STORE_DEPTH = MAX_BEAMS * MAX_SAMPLES;
  localparam int STW   = $clog2(STORE_DEPTH);
  localparam int BXW   = (BW > BEAM_OUT_W) ? BW : BEAM_OUT_W;
  localparam int SXW   = (SW > SAMP_OUT_W) ? SW : SAMP_OUT_W;

  sfp_state_t state_r, state_nxt;

  // configuration registers
  logic [NUM_BEAMS_W-1:0] nbeams_r;
  logic [NUM_SAMP_W-1:0]  nsamp_r;
  logic [GAIN_W-1:0]      lp_gain_r;
  logic [GAIN_W-1:0]      df_gain_r;

  // frame position and filter state
  logic [BW-1:0] beam_r;
  logic [SW-1:0] samp_r;
  logic signed [SAMPLE_W-1:0] raw0_r, raw1_r, axp_r;
  logic signed [SAMPLE_W-1:0] dly_r [DLEN];

  // per-word working registers
  logic signed [SAMPLE_W-1:0] x_r, m_r, y_r;
  logic [SW-1:0] q_r;
  logic          pend_r;
  logic          end_r;
  logic signed [LP_PROD_W-1:0] lp_prod_r;
  logic signed [DPW-1:0]       d_prod_r;
  logic                        last_r;

  // line buffer of the previous beam
  logic signed [SAMPLE_W-1:0] line_mem [MAX_SAMPLES];
  logic signed [SAMPLE_W-1:0] line_q_r;
  logic line_rd_en, line_wr_en;

  // output register
  logic out_valid_r;
  logic [BEAM_OUT_W-1:0] out_beam_r;
  logic [SAMP_OUT_W-1:0] out_samp_r;
  logic signed [STRAIN_W-1:0] out_sum_r;
  logic out_last_r;

  // store interface
  st_ctl_t st_ctl;
  logic [STW-1:0] st_addr;
  logic signed [STRAIN_W-1:0] st_rdata, st_wdata;
  logic st_busy;

  // effective geometry
  logic [ZB-1:0] nb_z, nb_eff;
  logic [ZS-1:0] ns_z, ns_eff;
  logic fr_bad, is_end;
  logic [BW-1:0] beam_e;
  logic [SW-1:0] p_e;
  logic signed [SAMPLE_W-1:0] raw0_e, raw1_e;

  // point datapath
  logic signed [SAMPLE_W-1:0] z_w;
  logic [SW-1:0] c_w;
  logic is_int;
  logic out_free;
  logic pt_done;
  logic signed [SUMW-1:0] dsum;
  logic signed [DPW-1:0]  dround;
  logic signed [DW-1:0]   dv;
  logic signed [ACW-1:0]  acc;
  logic [BXW-1:0] beam_x;
  logic [SXW-1:0] samp_x;

  assign nb_z   = ZB'(nbeams_r);
  assign nb_eff = (nb_z < ZB'(MIN_BEAMS)) ? ZB'(MIN_BEAMS) :
                  (nb_z > ZB'(MAX_BEAMS)) ? ZB'(MAX_BEAMS) : nb_z;
  assign ns_z   = ZS'(nsamp_r);
  assign ns_eff = (ns_z < ZS'(MIN_SAMPLES)) ? ZS'(MIN_SAMPLES) :
                  (ns_z > ZS'(MAX_SAMPLES)) ? ZS'(MAX_SAMPLES) : ns_z;

  // frame restart when the position lies outside the geometry
  assign fr_bad = (ZB'(beam_r) >= nb_eff) || (ZS'(samp_r) >= ns_eff);
  assign beam_e = fr_bad ? '0 : beam_r;
  assign p_e    = fr_bad ? '0 : samp_r;
  assign raw0_e = fr_bad ? '0 : raw0_r;
  assign raw1_e = fr_bad ? '0 : raw1_r;
  assign is_end = (ZS'(p_e) == ns_eff - ZS'(1));

  // point control
  assign is_int   = ({1'b0, q_r} >= (SW+1)'(2 * HALF_LEN));
  assign c_w      = q_r - SW'(HALF_LEN);
  assign out_free = !out_valid_r || out_ready;
  assign pt_done  = ((state_r == S_LATZ) && !is_int) || ((state_r == S_ACC) && out_free);
  assign z_w      = (beam_r == '0) ? y_r : lp_apply(line_q_r, lp_prod_r);

  // differentiator sum over the delay line
  always_comb begin
    dsum = '0;
    for (int i = 1; i <= HALF_LEN; i++) begin
      dsum = dsum + SUMW'(dly_r[HALF_LEN - i]) - SUMW'(dly_r[HALF_LEN + i]);
    end
  end

  // rounding and saturating accumulate
  always_comb begin
    dround = d_prod_r + DPW'(2048);
    dv     = DW'(dround >>> 12);
    acc    = ACW'(st_rdata) + ACW'(dv);
    if (acc > ACW'(32'sh7FFFFFFF)) begin
      st_wdata = 32'sh7FFFFFFF;
    end else if (acc < -ACW'(33'sh080000000)) begin
      st_wdata = 32'sh80000000;
    end else begin
      st_wdata = acc[STRAIN_W-1:0];
    end
  end

  assign st_addr = STW'(beam_r) * STW'(MAX_SAMPLES) + STW'(c_w);
  assign beam_x  = BXW'(beam_r);
  assign samp_x  = SXW'(c_w);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR:  if (!st_busy) state_nxt = S_IDLE;
      S_IDLE: if (in_valid && !cfg_valid && (p_e != '0)) state_nxt = S_AX;
      S_AX:   state_nxt = S_AXY;
      S_AXY:  state_nxt = S_LAT;
      S_LAT:  state_nxt = S_LATZ;
      S_LATZ: begin
        if (is_int) state_nxt = S_DIFF;
        else        state_nxt = pend_r ? S_AX : S_IDLE;
      end
      S_DIFF: state_nxt = S_ACC;
      S_ACC:  if (out_free) state_nxt = pend_r ? S_AX : S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready     = 1'b0;
    line_rd_en   = 1'b0;
    line_wr_en   = 1'b0;
    st_ctl.rd_en = 1'b0;
    st_ctl.wr_en = 1'b0;
    case (state_r)
      S_IDLE: in_ready = !cfg_valid;
      S_AX:   line_rd_en = 1'b1;
      S_LATZ: line_wr_en = 1'b1;
      S_DIFF: st_ctl.rd_en = 1'b1;
      S_ACC:  st_ctl.wr_en = out_free;
      default: ;
    endcase
  end

  // register writes only while no word is in flight
  assign cfg_ready = (state_r == S_IDLE) || (state_r == S_CLR);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLR;
    else        state_r <= state_nxt;
  end

  // line buffer
  always_ff @(posedge clk) begin
    if (line_wr_en) line_mem[q_r] <= z_w;
    if (line_rd_en) line_q_r <= line_mem[q_r];
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nbeams_r  <= RST_NUM_BEAMS;
      nsamp_r   <= RST_SAMPLES;
      lp_gain_r <= RST_LOWPASS;
      df_gain_r <= RST_DIFF_GAIN;
      beam_r    <= '0;
      samp_r    <= '0;
      raw0_r    <= '0;
      raw1_r    <= '0;
      axp_r     <= '0;
      pend_r    <= 1'b0;
      end_r     <= 1'b0;
      for (int i = 0; i < DLEN; i++) dly_r[i] <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            x_r    <= in_shift_sample;
            beam_r <= beam_e;
            pend_r <= is_end;
            end_r  <= is_end;
            q_r    <= p_e - SW'(1);
            m_r    <= (p_e == SW'(1)) ? raw1_e : med3(raw0_e, raw1_e, in_shift_sample);
            if (fr_bad) begin
              axp_r <= '0;
              for (int i = 0; i < DLEN; i++) dly_r[i] <= '0;
            end
            if (p_e == '0) begin
              // first word of a beam gives no point yet
              raw0_r <= raw1_e;
              raw1_r <= in_shift_sample;
              samp_r <= SW'(1);
            end else begin
              raw0_r <= raw0_e;
              raw1_r <= raw1_e;
              samp_r <= p_e;
            end
          end
        end
        S_AX: begin
          lp_prod_r <= LP_PROD_W'((SAMPLE_W+1)'(m_r) - (SAMPLE_W+1)'(axp_r)) *
                       LP_PROD_W'(signed'({1'b0, lp_gain_r}));
        end
        S_AXY: begin
          y_r   <= (q_r == '0) ? m_r : lp_apply(axp_r, lp_prod_r);
          axp_r <= (q_r == '0) ? m_r : lp_apply(axp_r, lp_prod_r);
        end
        S_LAT: begin
          lp_prod_r <= LP_PROD_W'((SAMPLE_W+1)'(y_r) - (SAMPLE_W+1)'(line_q_r)) *
                       LP_PROD_W'(signed'({1'b0, lp_gain_r}));
        end
        S_LATZ: begin
          for (int i = DLEN - 1; i > 0; i--) dly_r[i] <= dly_r[i-1];
          dly_r[0] <= z_w;
        end
        S_DIFF: begin
          d_prod_r <= DPW'(dsum) * DPW'(signed'({1'b0, df_gain_r}));
          last_r   <= (ZB'(beam_r) == nb_eff - ZB'(1)) &&
                      (ZS'(c_w) == ns_eff - ZS'(HALF_LEN) - ZS'(1));
        end
        default: ;
      endcase

      // point finished: next point of this word, or word done
      if (pt_done) begin
        if (pend_r) begin
          pend_r <= 1'b0;
          q_r    <= samp_r;
          m_r    <= x_r;
        end else begin
          raw0_r <= raw1_r;
          raw1_r <= x_r;
          if (end_r) begin
            samp_r <= '0;
            beam_r <= (ZB'(beam_r) + ZB'(1) >= nb_eff) ? '0 : beam_r + BW'(1);
          end else begin
            samp_r <= samp_r + SW'(1);
          end
        end
      end

      // register writes; geometry writes restart the frame
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_NUM_BEAMS, CFG_SAMPLES: begin
            if (cfg_index == CFG_NUM_BEAMS) nbeams_r <= cfg_data[NUM_BEAMS_W-1:0];
            else                            nsamp_r  <= cfg_data[NUM_SAMP_W-1:0];
            beam_r <= '0;
            samp_r <= '0;
            raw0_r <= '0;
            raw1_r <= '0;
            axp_r  <= '0;
            for (int i = 0; i < DLEN; i++) dly_r[i] <= '0;
          end
          CFG_LOWPASS:   lp_gain_r <= cfg_data;
          CFG_DIFF_GAIN: df_gain_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (st_ctl.wr_en) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st_ctl.wr_en) begin
      out_beam_r <= beam_x[BEAM_OUT_W-1:0];
      out_samp_r <= samp_x[SAMP_OUT_W-1:0];
      out_sum_r  <= st_wdata;
      out_last_r <= last_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_beam_index   = out_beam_r;
  assign out_sample_index = out_samp_r;
  assign out_strain_sum   = out_sum_r;
  assign out_frame_last   = out_last_r;

  sfp_strain_store #(
    .DEPTH (STORE_DEPTH),
    .AW    (STW)
  ) u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (st_ctl),
    .addr  (st_addr),
    .wdata (st_wdata),
    .rdata (st_rdata),
    .busy  (st_busy)
  );

endmodule

FILE: rtl/sfp_checker.sv
// sfp_checker: port-level checks of the strain field post-filter over time
// depends on sfp_pkg; bound to strain_field_postfilter

module sfp_checker
  import sfp_pkg::*;
(
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [STRAIN_W-1:0] out_strain_sum,
  input logic [SAMP_OUT_W-1:0]      out_sample_index
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_strain_sum)
      && $stable(out_sample_index))
    else $error("result word changed while stalled");

  // reset empties the output register
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // store clearing keeps input closed after reset
  a_rst_in: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input open during store clearing");

endmodule

bind strain_field_postfilter sfp_checker u_sfp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_strain_sum   (out_strain_sum),
  .out_sample_index (out_sample_index)
);

FILE: tb/tb_strain_field_postfilter.sv
// tb_strain_field_postfilter: self-checking bench for the strain field post-filter
// depends on sfp_pkg and strain_field_postfilter; predicts every store update word
`timescale 1ns / 100ps

module tb_strain_field_postfilter;
  import sfp_pkg::*;

  localparam int NUM_BEAMS_MAX = 128;
  localparam int NUM_SAMP_MAX  = 2048;
  localparam int HALF          = 5;
  localparam int TAPS          = 2 * HALF + 1;
  localparam int WATCHDOG_LIM  = 1000000;
  localparam int SETTLE_CYC    = 40;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = 4'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = 4'd15;

  typedef struct {
    logic [BEAM_OUT_W-1:0]      beam;
    logic [SAMP_OUT_W-1:0]      samp;
    logic signed [STRAIN_W-1:0] strain;
    logic                       last;
  } strain_word_t;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_shift_sample;
  logic                       out_valid;
  logic                       out_ready;
  logic [BEAM_OUT_W-1:0]      out_beam_index;
  logic [SAMP_OUT_W-1:0]      out_sample_index;
  logic signed [STRAIN_W-1:0] out_strain_sum;
  logic                       out_frame_last;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_data;

  strain_field_postfilter u_top (.*);

  // pending shift words and expected store updates
  logic signed [SAMPLE_W-1:0] shift_pend_q[$];
  strain_word_t               strain_expect_q[$];
  int  mismatches;
  int  idle_cycles;
  bit  calm;

  // predictor copy of registers and filter state
  int  reg_beams, reg_samples, reg_lp, reg_dg;
  int  beam_cur, samp_cur;
  int  raw_prev[2];
  int  axial_last;
  int  lateral_mem[NUM_SAMP_MAX];
  int  diff_taps[TAPS];
  int  strain_mem[int];

  // clock and reset
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic int beams_used();
    return (reg_beams < 2) ? 2 : (reg_beams > NUM_BEAMS_MAX ? NUM_BEAMS_MAX : reg_beams);
  endfunction

  function automatic int samples_used();
    return (reg_samples < 16) ? 16 : (reg_samples > NUM_SAMP_MAX ? NUM_SAMP_MAX : reg_samples);
  endfunction

  function automatic int lp_step(int prev, int x);
    longint d;
    d = longint'(x) - longint'(prev);
    return int'(longint'(prev) + ((d * longint'(reg_lp) + 64'sd32768) >>> 16));
  endfunction

  task automatic frame_restart();
    beam_cur = 0;
    samp_cur = 0;
    raw_prev[0] = 0;
    raw_prev[1] = 0;
    axial_last = 0;
    for (int i = 0; i < TAPS; i++) diff_taps[i] = 0;
  endtask

  task automatic apply_reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_NUM_BEAMS: begin
        reg_beams = int'(val[NUM_BEAMS_W-1:0]);
        frame_restart();
      end
      CFG_SAMPLES: begin
        reg_samples = int'(val[NUM_SAMP_W-1:0]);
        frame_restart();
      end
      CFG_LOWPASS:   reg_lp = int'(val);
      CFG_DIFF_GAIN: reg_dg = int'(val);
      default: ;
    endcase
  endtask

  // one point (median of three, or an edge sample as it is) through both low passes and the differentiator
  task automatic filter_point(int q, int m, int nb, int ns);
    int y, z, ctr, sat_v;
    longint s, d, acc;
    strain_word_t w;
    y = (q == 0) ? m : lp_step(axial_last, m);
    axial_last = y;
    z = (beam_cur == 0) ? y : lp_step(lateral_mem[q], y);
    lateral_mem[q] = z;
    for (int i = TAPS - 1; i > 0; i--) diff_taps[i] = diff_taps[i-1];
    diff_taps[0] = z;
    if (q >= 2 * HALF) begin
      ctr = q - HALF;
      s = 0;
      for (int i = 1; i <= HALF; i++)
        s += longint'(diff_taps[HALF-i]) - longint'(diff_taps[HALF+i]);
      d = (s * longint'(reg_dg) + 64'sd2048) >>> 12;
      acc = (strain_mem.exists(beam_cur * NUM_SAMP_MAX + ctr) ?
             longint'(strain_mem[beam_cur * NUM_SAMP_MAX + ctr]) : 0) + d;
      if (acc > 64'sd2147483647) acc = 64'sd2147483647;
      if (acc < -64'sd2147483648) acc = -64'sd2147483648;
      sat_v = int'(acc);
      strain_mem[beam_cur * NUM_SAMP_MAX + ctr] = sat_v;
      w.beam   = BEAM_OUT_W'(beam_cur);
      w.samp   = SAMP_OUT_W'(ctr);
      w.strain = sat_v;
      w.last   = (beam_cur == nb - 1) && (ctr == ns - HALF - 1);
      strain_expect_q.push_back(w);
    end
  endtask

  task automatic predict_shift_word(logic signed [SAMPLE_W-1:0] xs);
    int nb, ns, p, x, m;
    nb = beams_used();
    ns = samples_used();
    x = int'(xs);
    if (beam_cur >= nb || samp_cur >= ns) frame_restart();
    p = samp_cur;
    if (p >= 1) begin
      if (p == 1) m = raw_prev[1];
      else begin
        // true median of three
        m = (raw_prev[0] < raw_prev[1]) ? raw_prev[1] : raw_prev[0];
        if (x < m) m = x;
        if (((raw_prev[0] < raw_prev[1]) ? raw_prev[0] : raw_prev[1]) > m)
          m = (raw_prev[0] < raw_prev[1]) ? raw_prev[0] : raw_prev[1];
      end
      filter_point(p - 1, m, nb, ns);
    end
    if (p == ns - 1) filter_point(p, x, nb, ns);
    raw_prev[0] = raw_prev[1];
    raw_prev[1] = x;
    if (p == ns - 1) begin
      samp_cur = 0;
      beam_cur = (beam_cur + 1 >= nb) ? 0 : beam_cur + 1;
    end else begin
      samp_cur = p + 1;
    end
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_shift_sample <= '0;
    end else begin
      if (in_valid && in_ready) predict_shift_word(in_shift_sample);
      if (!in_valid || in_ready) begin
        if (shift_pend_q.size() > 0 && (calm || $urandom_range(0, 99) >= 9)) begin
          in_valid <= 1'b1;
          in_shift_sample <= shift_pend_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and output stalls
  always @(posedge clk) begin
    strain_word_t w;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= 9);
      if (out_valid && out_ready) begin
        if (strain_expect_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: beam %0d sample %0d strain %0d last %0b",
                     out_beam_index, out_sample_index, out_strain_sum, out_frame_last);
        end else begin
          w = strain_expect_q.pop_front();
          if (w.beam !== out_beam_index || w.samp !== out_sample_index ||
              w.strain !== out_strain_sum || w.last !== out_frame_last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp b%0d s%0d v%0d l%0b, got b%0d s%0d v%0d l%0b",
                       w.beam, w.samp, w.strain, w.last, out_beam_index,
                       out_sample_index, out_strain_sum, out_frame_last);
          end
        end
      end
    end
  end

  // watchdog on cycles with no handshake anywhere
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIM) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    apply_reg_write(idx, val);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    forever begin
      @(posedge clk);
      if (shift_pend_q.size() == 0 && !in_valid && strain_expect_q.size() == 0) break;
    end
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // smooth ramp with noise mostly, some full-range and extreme words
  task automatic queue_words(int count);
    int base, slope, pick;
    base  = int'($urandom_range(0, 4000)) - 2000;
    slope = int'($urandom_range(0, 400)) - 200;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 19);
      if (pick == 0)      shift_pend_q.push_back(SAMPLE_W'($urandom));
      else if (pick == 1) shift_pend_q.push_back($urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000);
      else shift_pend_q.push_back(SAMPLE_W'(base + k * slope + int'($urandom_range(0, 64)) - 32));
    end
  endtask

  initial begin
    int nb_w, ns_w, cnt;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    calm = 1'b0;
    mismatches = 0;
    reg_beams = RST_NUM_BEAMS;
    reg_samples = RST_SAMPLES;
    reg_lp = RST_LOWPASS;
    reg_dg = RST_DIFF_GAIN;
    frame_restart();
    @(posedge clk);
    wait (rst_n === 1'b1);

    // directed: smallest geometry, extreme gains, extreme words
    reg_write(CFG_NUM_BEAMS, 16'd2);
    reg_write(CFG_SAMPLES, 16'd16);
    reg_write(CFG_LOWPASS, 16'hffff);
    reg_write(CFG_DIFF_GAIN, 16'hffff);
    reg_write(CFG_UNUSED_A, 16'h1234);
    shift_pend_q = {24'sh800000, 24'sh7fffff, 24'sh000000, 24'shffffff, 24'sh000001,
                    24'sh555555, 24'shaaaaaa, 24'sh7fffff, 24'sh800000, 24'sh7fffff,
                    24'sh800000, 24'sh000000, 24'sh7fffff, 24'sh7fffff, 24'sh800000,
                    24'sh123456, 24'shedcba9, 24'sh000100, 24'sh7fffff, 24'sh800000};
    drain();
    reg_write(CFG_LOWPASS, 16'h0000);
    reg_write(CFG_DIFF_GAIN, 16'h0000);
    reg_write(CFG_UNUSED_B, 16'hffff);
    queue_words(4);
    drain();

    // random geometry and gains, clamped register values among them
    for (int ph = 0; ph < 6; ph++) begin
      calm = (ph == 4);
      case ($urandom_range(0, 4))
        0: nb_w = 0;
        1: nb_w = 1;
        2: nb_w = 2;
        default: nb_w = $urandom_range(3, 6);
      endcase
      case ($urandom_range(0, 4))
        0: ns_w = $urandom_range(0, 15);
        1: ns_w = 16;
        default: ns_w = $urandom_range(17, 40);
      endcase
      reg_write(CFG_NUM_BEAMS, CFG_DATA_W'(nb_w) | (CFG_DATA_W'($urandom_range(0, 1)) << 12));
      reg_write(CFG_SAMPLES, CFG_DATA_W'(ns_w));
      reg_write(CFG_LOWPASS, ($urandom_range(0, 3) == 0) ? 16'hffff : CFG_DATA_W'($urandom));
      reg_write(CFG_DIFF_GAIN, ($urandom_range(0, 3) == 0) ? 16'hffff : CFG_DATA_W'($urandom));
      cnt = (nb_w < 2 ? 2 : nb_w) * (ns_w < 16 ? 16 : ns_w);
      queue_words(cnt * 2 + $urandom_range(0, 20));
      drain();
    end
    calm = 1'b0;

    // long beam, register values above and below range
    reg_write(CFG_SAMPLES, 16'h0fff);
    reg_write(CFG_NUM_BEAMS, 16'd0);
    reg_write(CFG_LOWPASS, 16'd5644);
    reg_write(CFG_DIFF_GAIN, 16'd2185);
    queue_words(600);
    drain();

    // most beams with short beams
    reg_write(CFG_NUM_BEAMS, 16'h00ff);
    reg_write(CFG_SAMPLES, 16'd16);
    queue_words(200);
    drain();

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
